// ===== hw/rtl/hsv_to_rgb_converter_assert.svh =====
// Assertion macros for the HSV to RGB converter checker
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define HSV2RGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define HSV2RGB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Shared types and constants of the HSV to RGB converter
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  // field widths
  localparam int unsigned HueFracBits = 4;
  localparam int unsigned ChannelBits = 8;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned HueW        = 9 + HueFracBits;

  // hue constants, in hue LSBs
  localparam int unsigned Deg60  = 60 << HueFracBits;
  localparam int unsigned Deg360 = 360 << HueFracBits;

  localparam int unsigned ChMax   = (1 << ChannelBits) - 1;
  localparam int unsigned FracOne = 1 << FracBits;
  localparam int unsigned Den     = ChMax * FracOne;

  // sector fraction: floor(rem * FracOne / Deg60) by reciprocal multiply
  localparam int unsigned     RemW       = $clog2(Deg60);
  localparam int unsigned     Deg60W     = $clog2(Deg60 + 1);
  localparam int unsigned     FracShift  = RemW + FracBits + Deg60W;
  localparam longint unsigned FracRecip  = ((64'd1 << FracShift) + Deg60 - 1) / Deg60;
  localparam int unsigned     FracRecipW = $clog2(FracRecip + 1);

  // channel scaling: floor(prod / Den) by reciprocal multiply
  localparam int unsigned     DenW      = $clog2(Den + 1);
  localparam int unsigned     ProdW     = ChannelBits + DenW;
  localparam int unsigned     DivShift  = ProdW + DenW;
  localparam longint unsigned DivRecip  = ((64'd1 << DivShift) + Den - 1) / Den;
  localparam int unsigned     DivRecipW = $clog2(DivRecip + 1);

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0]        hue;
    logic [ChannelBits-1:0] saturation;
    logic [ChannelBits-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChannelBits-1:0] red;
    logic [ChannelBits-1:0] green;
    logic [ChannelBits-1:0] blue;
  } rgb_t;

  // classified word: what the back end needs
  typedef struct packed {
    sector_e                sector;
    logic [FracBits-1:0]    frac;
    logic [ChannelBits-1:0] saturation;
    logic [ChannelBits-1:0] brightness;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsv2rgb_front.sv =====
// Front end: accepts words, wraps the hue, finds sector and fraction
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  hsv2rgb_pkg::hsv_t    hsv_i,
  input  hsv2rgb_pkg::q_stat_t q_stat_i,
  output logic                 busy_o,
  output logic                 push_o,
  output hsv2rgb_pkg::cls_t    cls_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned FracProdW = RemW + FracRecipW;

  typedef struct packed {
    logic [RemW-1:0]        rem;
    sector_e                sector;
    logic [ChannelBits-1:0] saturation;
    logic [ChannelBits-1:0] brightness;
  } split_t;

  logic   a_valid_q, a_valid_d;
  hsv_t   a_item_q;
  logic   b_valid_q, b_valid_d;
  split_t b_item_q, b_item_d;

  logic   accept, a_move, b_ready, push;
  logic [HueW-1:0]      hue_wrap;
  logic [HueW-1:0]      sect_base;
  logic [FracProdW-1:0] frac_prod;

  // handshake between the two front stages and the queue
  assign push    = b_valid_q && !q_stat_i.full;
  assign b_ready = !b_valid_q || push;
  assign a_move  = a_valid_q && b_ready;
  assign busy_o  = a_valid_q && !b_ready;
  assign accept  = start_i && !busy_o;

  assign a_valid_d = accept || (a_valid_q && !a_move);
  assign b_valid_d = a_move || (b_valid_q && !push);

  // stage A -> B: wrap, sector by compare, remainder within sector
  always_comb begin
    hue_wrap = (a_item_q.hue >= HueW'(Deg360)) ? '0 : a_item_q.hue;
    priority if (hue_wrap >= HueW'(5 * Deg60)) begin
      b_item_d.sector = SecMagRed;
      sect_base       = HueW'(5 * Deg60);
    end else if (hue_wrap >= HueW'(4 * Deg60)) begin
      b_item_d.sector = SecBluMag;
      sect_base       = HueW'(4 * Deg60);
    end else if (hue_wrap >= HueW'(3 * Deg60)) begin
      b_item_d.sector = SecCynBlu;
      sect_base       = HueW'(3 * Deg60);
    end else if (hue_wrap >= HueW'(2 * Deg60)) begin
      b_item_d.sector = SecGrnCyn;
      sect_base       = HueW'(2 * Deg60);
    end else if (hue_wrap >= HueW'(Deg60)) begin
      b_item_d.sector = SecYelGrn;
      sect_base       = HueW'(Deg60);
    end else begin
      b_item_d.sector = SecRedYel;
      sect_base       = '0;
    end
    b_item_d.rem        = RemW'(hue_wrap - sect_base);
    b_item_d.saturation = a_item_q.saturation;
    b_item_d.brightness = a_item_q.brightness;
  end

  // stage B -> queue: fraction = rem * FracOne / Deg60 via reciprocal
  assign frac_prod = FracProdW'(b_item_q.rem) * FracProdW'(FracRecip);

  assign push_o           = push;
  assign cls_o.sector     = b_item_q.sector;
  assign cls_o.frac       = frac_prod[FracShift-FracBits +: FracBits];
  assign cls_o.saturation = b_item_q.saturation;
  assign cls_o.brightness = b_item_q.brightness;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= hsv_i;
    end
    if (a_move) begin
      b_item_q <= b_item_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_fifo.sv =====
// Short queue of classified words between front and back ends
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hsv2rgb_pkg::cls_t    cls_i,
  input  logic                 pop_i,
  output hsv2rgb_pkg::cls_t    cls_o,
  output hsv2rgb_pkg::q_stat_t q_stat_o
);
  import hsv2rgb_pkg::*;

  cls_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign q_stat_o.empty = (cnt_q == '0);

  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;

  assign cls_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cls_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_back.sv =====
// Back end: forms p, q, t, scales them and routes channels by sector
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hsv2rgb_pkg::q_stat_t q_stat_i,
  input  hsv2rgb_pkg::cls_t    cls_i,
  output logic                 pop_o,
  output logic                 done_o,
  output hsv2rgb_pkg::rgb_t    rgb_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned DivProdW = ProdW + DivRecipW;

  // stage 1: saturation products
  logic                   s1_valid_q;
  logic [DenW-1:0]        x_p_q, x_q_q, x_t_q;
  logic [DenW-1:0]        x_p_d, x_q_d, x_t_d;
  logic [ChannelBits-1:0] s1_v_q;
  sector_e                s1_sec_q;
  logic [FracBits:0]      inv_frac;

  // stage 2: brightness products
  logic                   s2_valid_q;
  logic [ProdW-1:0]       pr_p_q, pr_q_q, pr_t_q;
  logic [ChannelBits-1:0] s2_v_q;
  sector_e                s2_sec_q;

  // stage 3: divide by Den, route
  logic [DivProdW-1:0]    dv_p, dv_q, dv_t;
  logic [ChannelBits-1:0] ch_p, ch_q, ch_t;
  rgb_t                   rgb_q, rgb_d;
  logic                   done_q;

  // never stalls: drain the queue whenever it holds a word
  assign pop_o = !q_stat_i.empty;

  assign inv_frac = (FracBits+1)'(FracOne) - {1'b0, cls_i.frac};
  assign x_p_d    = DenW'(cls_i.saturation) << FracBits;
  assign x_q_d    = DenW'(cls_i.saturation) * DenW'(cls_i.frac);
  assign x_t_d    = DenW'(cls_i.saturation) * DenW'(inv_frac);

  assign dv_p = DivProdW'(pr_p_q) * DivProdW'(DivRecip);
  assign dv_q = DivProdW'(pr_q_q) * DivProdW'(DivRecip);
  assign dv_t = DivProdW'(pr_t_q) * DivProdW'(DivRecip);
  assign ch_p = dv_p[DivShift +: ChannelBits];
  assign ch_q = dv_q[DivShift +: ChannelBits];
  assign ch_t = dv_t[DivShift +: ChannelBits];

  always_comb begin
    unique case (s2_sec_q)
      SecRedYel: rgb_d = '{red: s2_v_q, green: ch_t,   blue: ch_p};
      SecYelGrn: rgb_d = '{red: ch_q,   green: s2_v_q, blue: ch_p};
      SecGrnCyn: rgb_d = '{red: ch_p,   green: s2_v_q, blue: ch_t};
      SecCynBlu: rgb_d = '{red: ch_p,   green: ch_q,   blue: s2_v_q};
      SecBluMag: rgb_d = '{red: ch_t,   green: ch_p,   blue: s2_v_q};
      default:   rgb_d = '{red: s2_v_q, green: ch_p,   blue: ch_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_p_q    <= x_p_d;
    x_q_q    <= x_q_d;
    x_t_q    <= x_t_d;
    s1_v_q   <= cls_i.brightness;
    s1_sec_q <= cls_i.sector;

    pr_p_q   <= ProdW'(s1_v_q) * ProdW'(DenW'(Den) - x_p_q);
    pr_q_q   <= ProdW'(s1_v_q) * ProdW'(DenW'(Den) - x_q_q);
    pr_t_q   <= ProdW'(s1_v_q) * ProdW'(DenW'(Den) - x_t_q);
    s2_v_q   <= s1_v_q;
    s2_sec_q <= s1_sec_q;

    rgb_q    <= rgb_d;
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB converter. One word in, one RGB word out, no state between
// words. A word is taken at a rising edge with start_i high and busy_o
// low; hue is degrees in unsigned Q9.4 (360.0 and up reads as 0),
// saturation and brightness are 8-bit fractions of 255. Each result shows
// on rgb_o for exactly one cycle with done_o high, in input order, and the
// receiver cannot hold it off. Throughput is one word per clock while
// busy_o is low; each word is registered at stage A, stage B, the queue,
// both back-end product stages and the output before done_o rises. The
// front end (two stages: hue wrap and sector compare, then a reciprocal
// multiply for the in-sector fraction) feeds a two-word queue; the back
// end (saturation products, brightness products, reciprocal divide by
// 255*256 with channel routing) drains it every cycle, so busy_o stays
// low in normal use. Products truncate toward zero; zero saturation gives
// grey.
module hsv_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  hsv2rgb_pkg::hsv_t  hsv_i,
  output logic               busy_o,
  output logic               done_o,
  output hsv2rgb_pkg::rgb_t  rgb_o
);
  import hsv2rgb_pkg::*;

  q_stat_t q_stat;
  cls_t    front_cls;
  cls_t    queue_cls;
  logic    push;
  logic    pop;

  hsv2rgb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .hsv_i    (hsv_i),
    .q_stat_i (q_stat),
    .busy_o   (busy_o),
    .push_o   (push),
    .cls_o    (front_cls)
  );

  hsv2rgb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cls_i    (front_cls),
    .pop_i    (pop),
    .cls_o    (queue_cls),
    .q_stat_o (q_stat)
  );

  hsv2rgb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .cls_i    (queue_cls),
    .pop_o    (pop),
    .done_o   (done_o),
    .rgb_o    (rgb_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input hsv2rgb_pkg::hsv_t hsv_i,
  input logic              busy_o,
  input logic              done_o,
  input hsv2rgb_pkg::rgb_t rgb_o
);
  import hsv2rgb_pkg::*;

  // edges from the accepting edge to the edge that samples done_o
  localparam int unsigned ResultLag = 6;

  logic accept;
  assign accept = start_i && !busy_o;

  `HSV2RGB_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o, "converter stalled its input")
  `HSV2RGB_ASSERT_IMPL(a_word_out, clk_i, rst_ni, accept, ##ResultLag done_o, "result missing")
  `HSV2RGB_ASSERT_IMPL(a_no_extra, clk_i, rst_ni, done_o, $past(accept, ResultLag), "spurious result")
  `HSV2RGB_ASSERT_IMPL(a_grey, clk_i, rst_ni, done_o && ($past(hsv_i.saturation, ResultLag) == '0), (rgb_o.red == $past(hsv_i.brightness, ResultLag)) && (rgb_o.green == $past(hsv_i.brightness, ResultLag)) && (rgb_o.blue == $past(hsv_i.brightness, ResultLag)), "zero saturation not grey")
  `HSV2RGB_ASSERT_IMPL(a_peak, clk_i, rst_ni, done_o, (rgb_o.red <= $past(hsv_i.brightness, ResultLag)) && (rgb_o.green <= $past(hsv_i.brightness, ResultLag)) && (rgb_o.blue <= $past(hsv_i.brightness, ResultLag)) && ((rgb_o.red == $past(hsv_i.brightness, ResultLag)) || (rgb_o.green == $past(hsv_i.brightness, ResultLag)) || (rgb_o.blue == $past(hsv_i.brightness, ResultLag))), "largest channel differs from value")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .hsv_i   (hsv_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rgb_o   (rgb_o)
);

`default_nettype wire
